[hdl/calendar_clock_with_alarm_queue_top_macros.svh]
// Assertion helpers for the calendar clock top level.
`ifndef CALENDAR_CLOCK_WITH_ALARM_QUEUE_TOP_MACROS_SVH
`define CALENDAR_CLOCK_WITH_ALARM_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CCAQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccaq: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CCAQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccaq: next-cycle check failed");

`endif

[hdl/ccaq_pkg.sv]
`timescale 1ns / 1ps

package ccaq_pkg;

  localparam int unsigned QueueDepthDef    = 32;
  localparam int unsigned TicksPerFifthDef = 12;
  localparam int unsigned MaxResults       = 32;

  localparam logic [15:0] StartYear  = 16'd2155;
  localparam logic [4:0]  ResetDay   = 5'd17;
  localparam logic [3:0]  ResetMonth = 4'd2;

  // operation codes
  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpAdd    = 2'd1;
  localparam logic [1:0] OpRate   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  // result kinds
  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindFired = 2'd1;
  localparam logic [1:0] KindTick  = 2'd2;
  localparam logic [1:0] KindRate  = 2'd3;

  // add status codes
  localparam logic [1:0] StatQueued = 2'd0;
  localparam logic [1:0] StatNow    = 2'd1;
  localparam logic [1:0] StatPast   = 2'd2;
  localparam logic [1:0] StatFull   = 2'd3;

  // divisibility by 25 through the inverse of 25 modulo 2^16
  localparam logic [15:0] Inv25   = 16'd23593;
  localparam logic [15:0] Lim25   = 16'd2621;

  typedef struct packed {
    logic [1:0]  op;
    logic        relative;
    logic [7:0]  alarm_month;
    logic [7:0]  alarm_day;
    logic [15:0] alarm_year;
    logic [7:0]  alarm_tag;
    logic [15:0] day_secs;
  } ccaq_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fired_tag;
    logic [1:0]  add_status;
    logic [4:0]  now_day;
    logic [3:0]  now_month;
    logic [15:0] now_year;
    logic        day_rolled;
    logic        last;
  } ccaq_out_t;

  // one queued alarm; the date part compares as one number
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  tag;
  } ccaq_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_POP_RD,
    ST_POP_CMP,
    ST_ADD,
    ST_REL_M,
    ST_REL_D,
    ST_CHECK,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RATE_MUL,
    ST_RATE_PRD,
    ST_RATE_DIV,
    ST_RATE_END
  } ccaq_state_e;

  // Gregorian leap year
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] p;
    logic        d25;
    p   = 16'(y * Inv25);
    d25 = (p <= Lim25);
    return (y[1:0] == 2'd0) && (!d25 || (y[3:0] == 4'd0));
  endfunction

  // days in month m of year y, 0 for a month outside 1..12
  function automatic logic [4:0] days_of(input logic [3:0] m, input logic [15:0] y);
    logic [4:0] d;
    unique case (m)
      4'd2:                                     d = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                  d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      default:                                  d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

[hdl/calendar_clock_with_alarm_queue_top.sv]
`timescale 1ns / 1ps
// Channel  | Ports                          | Carries
// input    | in_valid_i/in_ready_o/in_data_i  | op and alarm or day-length fields
// output   | out_valid_o/out_ready_i/out_data_o | one or more results per transaction
//
// Tick: counts down; at zero the date advances and due alarms are popped from the queue head.
// Add: absolute dates are range-checked; relative offsets are carried through months and days,
// then the insertion pass shifts later queued entries up (one memory read per compare).
// Set day length: runs the 41-step restoring divider, skipped when no ticks remain or no length is set.
// Reset loads Feb 17 of the start year, zeros the counters and queue count; memory is kept.
// A full output register stalls the sequencer; input is taken only in idle.

`include "calendar_clock_with_alarm_queue_top_macros.svh"

module calendar_clock_with_alarm_queue_top #(
  parameter int unsigned QUEUE_DEPTH            = ccaq_pkg::QueueDepthDef,
  parameter int unsigned TICKS_PER_FIFTH_SECOND = ccaq_pkg::TicksPerFifthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccaq_pkg::ccaq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccaq_pkg::ccaq_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ResW = $clog2(ccaq_pkg::MaxResults + 1);

  // control state
  ccaq_pkg::ccaq_state_e state_q, state_d;
  logic [20:0]     tl_q, tl_d;
  logic [19:0]     dl_q, dl_d;
  logic [4:0]      day_q, day_d;
  logic [3:0]      mon_q, mon_d;
  logic [15:0]     yr_q, yr_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] i_q, i_d;
  logic            pend_q, pend_d;
  logic [ResW-1:0] nres_q, nres_d;
  logic [5:0]      dcnt_q, dcnt_d;
  logic            out_valid_q, out_valid_d;

  // payload
  ccaq_pkg::ccaq_in_t  in_q, in_d;
  ccaq_pkg::ccaq_out_t out_q, out_d;
  logic [8:0]  nm_q, nm_d;
  logic [8:0]  nd_q, nd_d;
  logic [15:0] ny_q, ny_d;
  logic [7:0]  ptag_q, ptag_d;
  logic [40:0] prod_q, prod_d;
  logic [19:0] rem_q, rem_d;
  logic [20:0] quo_q, quo_d;
  logic [19:0] nl_q, nl_d;
  logic        minone_q, minone_d;

  // alarm memory
  ccaq_pkg::ccaq_entry_t mem_q [QUEUE_DEPTH];
  ccaq_pkg::ccaq_entry_t rd_q;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_wa;
  ccaq_pkg::ccaq_entry_t mem_wd;

  logic                slot_free;
  logic                emit;
  ccaq_pkg::ccaq_out_t eo;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ccaq_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // queue position i relative to head, wrapped into the memory
  function automatic logic [IdxW-1:0] phys(input logic [CntW-1:0] i);
    logic [CntW:0] s;
    s = (CntW + 1)'(head_q) + (CntW + 1)'(i);
    if (s >= (CntW + 1)'(QUEUE_DEPTH)) begin
      s = s - (CntW + 1)'(QUEUE_DEPTH);
    end
    return IdxW'(s);
  endfunction

  // sequencer
  always_comb begin
    logic [20:0] tl_dec;
    logic [4:0]  dm;
    logic [24:0] new_date;
    logic [24:0] cur_date;
    logic        match;
    logic [20:0] rem_sh;
    ccaq_pkg::ccaq_entry_t ne;

    state_d     = state_q;
    tl_d        = tl_q;
    dl_d        = dl_q;
    day_d       = day_q;
    mon_d       = mon_q;
    yr_d        = yr_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    pend_d      = pend_q;
    nres_d      = nres_q;
    dcnt_d      = dcnt_q;
    in_d        = in_q;
    nm_d        = nm_q;
    nd_d        = nd_q;
    ny_d        = ny_q;
    ptag_d      = ptag_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    nl_d        = nl_q;
    minone_d    = minone_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    emit        = 1'b0;
    eo          = '0;
    eo.now_day   = day_q;
    eo.now_month = mon_q;
    eo.now_year  = yr_q;
    eo.last      = 1'b1;

    tl_dec   = (tl_q != '0) ? tl_q - 21'd1 : '0;
    new_date = {ny_q, nm_q[3:0], nd_q[4:0]};
    cur_date = {yr_q, mon_q, day_q};
    match    = (cnt_q != '0) && (rd_q[32:8] == cur_date);
    rem_sh   = {rem_q, prod_q[40]};
    ne.year  = ny_q;
    ne.month = nm_q[3:0];
    ne.day   = nd_q[4:0];
    ne.tag   = in_q.alarm_tag;
    dm       = '0;

    unique case (state_q)
      ccaq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          unique case (in_data_i.op)
            ccaq_pkg::OpTick: state_d = ccaq_pkg::ST_TICK;
            ccaq_pkg::OpAdd:  state_d = ccaq_pkg::ST_ADD;
            ccaq_pkg::OpRate: state_d = ccaq_pkg::ST_RATE_MUL;
            default:          state_d = ccaq_pkg::ST_IDLE;
          endcase
        end
      end

      // count down; reload and advance the date at zero
      ccaq_pkg::ST_TICK: begin
        if (tl_dec == '0 && dl_q != '0) begin
          tl_d = 21'(dl_q);
          dm   = ccaq_pkg::days_of(mon_q, yr_q);
          if (day_q >= dm) begin
            day_d = 5'd1;
            if (mon_q == 4'd12) begin
              mon_d = 4'd1;
              yr_d  = yr_q + 16'd1;
            end else begin
              mon_d = mon_q + 4'd1;
            end
          end else begin
            day_d = day_q + 5'd1;
          end
          nres_d  = '0;
          pend_d  = 1'b0;
          state_d = ccaq_pkg::ST_POP_RD;
        end else if (slot_free) begin
          tl_d    = (tl_dec == '0) ? 21'(dl_q) : tl_dec;
          emit    = 1'b1;
          eo.kind = ccaq_pkg::KindTick;
          state_d = ccaq_pkg::ST_IDLE;
        end
      end

      ccaq_pkg::ST_POP_RD: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
        state_d = ccaq_pkg::ST_POP_CMP;
      end

      // one result is held back so that the final one carries last
      ccaq_pkg::ST_POP_CMP: begin
        eo.day_rolled = 1'b1;
        if (match) begin
          if (nres_q == ResW'(ccaq_pkg::MaxResults) || !pend_q || slot_free) begin
            if (nres_q != ResW'(ccaq_pkg::MaxResults)) begin
              if (pend_q) begin
                emit         = 1'b1;
                eo.kind      = ccaq_pkg::KindFired;
                eo.fired_tag = ptag_q;
                eo.last      = 1'b0;
              end
              pend_d = 1'b1;
              ptag_d = rd_q.tag;
              nres_d = nres_q + ResW'(1);
            end
            head_d  = (head_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
            cnt_d   = cnt_q - CntW'(1);
            state_d = ccaq_pkg::ST_POP_RD;
          end
        end else if (slot_free) begin
          emit = 1'b1;
          if (pend_q) begin
            eo.kind      = ccaq_pkg::KindFired;
            eo.fired_tag = ptag_q;
          end else begin
            eo.kind = ccaq_pkg::KindTick;
          end
          state_d = ccaq_pkg::ST_IDLE;
        end
      end

      ccaq_pkg::ST_ADD: begin
        if (in_q.relative) begin
          if (in_q.alarm_month == '0 && in_q.alarm_day == '0 && in_q.alarm_year == '0) begin
            if (slot_free) begin
              emit          = 1'b1;
              eo.kind       = ccaq_pkg::KindAdd;
              eo.fired_tag  = in_q.alarm_tag;
              eo.add_status = ccaq_pkg::StatNow;
              state_d       = ccaq_pkg::ST_IDLE;
            end
          end else begin
            nm_d    = 9'(in_q.alarm_month) + 9'(mon_q) - 9'd1;
            nd_d    = 9'(in_q.alarm_day) + 9'(day_q);
            ny_d    = in_q.alarm_year + yr_q;
            state_d = ccaq_pkg::ST_REL_M;
          end
        end else begin
          if (in_q.alarm_month >= 8'd1 && in_q.alarm_month <= 8'd12) begin
            dm = ccaq_pkg::days_of(in_q.alarm_month[3:0], in_q.alarm_year);
          end
          if (in_q.alarm_day == '0 || in_q.alarm_day > 8'(dm)) begin
            if (slot_free) begin
              emit          = 1'b1;
              eo.kind       = ccaq_pkg::KindAdd;
              eo.add_status = ccaq_pkg::StatPast;
              state_d       = ccaq_pkg::ST_IDLE;
            end
          end else begin
            nm_d    = 9'(in_q.alarm_month);
            nd_d    = 9'(in_q.alarm_day);
            ny_d    = in_q.alarm_year;
            state_d = ccaq_pkg::ST_CHECK;
          end
        end
      end

      // fold month offset into years, twelve at a time
      ccaq_pkg::ST_REL_M: begin
        if (nm_q >= 9'd12) begin
          nm_d = nm_q - 9'd12;
          ny_d = ny_q + 16'd1;
        end else begin
          nm_d    = nm_q + 9'd1;
          state_d = ccaq_pkg::ST_REL_D;
        end
      end

      // carry days through month lengths, one month per cycle
      ccaq_pkg::ST_REL_D: begin
        dm = ccaq_pkg::days_of(nm_q[3:0], ny_q);
        if (nd_q > 9'(dm)) begin
          nd_d = nd_q - 9'(dm);
          if (nm_q == 9'd12) begin
            nm_d = 9'd1;
            ny_d = ny_q + 16'd1;
          end else begin
            nm_d = nm_q + 9'd1;
          end
        end else begin
          state_d = ccaq_pkg::ST_CHECK;
        end
      end

      ccaq_pkg::ST_CHECK: begin
        if (new_date < cur_date || cnt_q == CntW'(QUEUE_DEPTH)) begin
          if (slot_free) begin
            emit          = 1'b1;
            eo.kind       = ccaq_pkg::KindAdd;
            eo.add_status = (new_date < cur_date) ? ccaq_pkg::StatPast : ccaq_pkg::StatFull;
            state_d       = ccaq_pkg::ST_IDLE;
          end
        end else begin
          i_d     = cnt_q;
          state_d = ccaq_pkg::ST_INS_RD;
        end
      end

      // insertion pass from the tail toward the head
      ccaq_pkg::ST_INS_RD: begin
        if (i_q == '0) begin
          if (slot_free) begin
            mem_we  = 1'b1;
            mem_wa  = phys(i_q);
            mem_wd  = ne;
            cnt_d   = cnt_q + CntW'(1);
            emit    = 1'b1;
            eo.kind = ccaq_pkg::KindAdd;
            state_d = ccaq_pkg::ST_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys(i_q - CntW'(1));
          state_d = ccaq_pkg::ST_INS_CMP;
        end
      end

      ccaq_pkg::ST_INS_CMP: begin
        if (rd_q[32:8] > new_date) begin
          mem_we  = 1'b1;
          mem_wa  = phys(i_q);
          mem_wd  = rd_q;
          i_d     = i_q - CntW'(1);
          state_d = ccaq_pkg::ST_INS_RD;
        end else if (slot_free) begin
          mem_we  = 1'b1;
          mem_wa  = phys(i_q);
          mem_wd  = ne;
          cnt_d   = cnt_q + CntW'(1);
          emit    = 1'b1;
          eo.kind = ccaq_pkg::KindAdd;
          state_d = ccaq_pkg::ST_IDLE;
        end
      end

      ccaq_pkg::ST_RATE_MUL: begin
        nl_d    = 20'(20'(in_q.day_secs) * 20'(TICKS_PER_FIFTH_SECOND));
        state_d = ccaq_pkg::ST_RATE_PRD;
      end

      ccaq_pkg::ST_RATE_PRD: begin
        minone_d = 1'b0;
        if (dl_q == '0) begin
          quo_d   = 21'(nl_q);
          state_d = ccaq_pkg::ST_RATE_END;
        end else if (tl_q == '0) begin
          quo_d   = '0;
          state_d = ccaq_pkg::ST_RATE_END;
        end else begin
          prod_d   = 41'(tl_q) * 41'(nl_q);
          rem_d    = '0;
          quo_d    = '0;
          dcnt_d   = 6'd40;
          minone_d = 1'b1;
          state_d  = ccaq_pkg::ST_RATE_DIV;
        end
      end

      // restoring division, one quotient bit per cycle
      ccaq_pkg::ST_RATE_DIV: begin
        prod_d = {prod_q[39:0], 1'b0};
        if (rem_sh >= 21'(dl_q)) begin
          rem_d = 20'(rem_sh - 21'(dl_q));
          quo_d = {quo_q[19:0], 1'b1};
        end else begin
          rem_d = rem_sh[19:0];
          quo_d = {quo_q[19:0], 1'b0};
        end
        dcnt_d = dcnt_q - 6'd1;
        if (dcnt_q == '0) begin
          state_d = ccaq_pkg::ST_RATE_END;
        end
      end

      ccaq_pkg::ST_RATE_END: begin
        if (slot_free) begin
          dl_d    = nl_q;
          tl_d    = (minone_q && quo_q == '0) ? 21'd1 : quo_q;
          emit    = 1'b1;
          eo.kind = ccaq_pkg::KindRate;
          state_d = ccaq_pkg::ST_IDLE;
        end
      end

      default: state_d = ccaq_pkg::ST_IDLE;
    endcase

    // output register
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = eo;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccaq_pkg::ST_IDLE;
      tl_q        <= '0;
      dl_q        <= '0;
      day_q       <= ccaq_pkg::ResetDay;
      mon_q       <= ccaq_pkg::ResetMonth;
      yr_q        <= ccaq_pkg::StartYear;
      head_q      <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      pend_q      <= 1'b0;
      nres_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tl_q        <= tl_d;
      dl_q        <= dl_d;
      day_q       <= day_d;
      mon_q       <= mon_d;
      yr_q        <= yr_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      pend_q      <= pend_d;
      nres_q      <= nres_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    out_q    <= out_d;
    nm_q     <= nm_d;
    nd_q     <= nd_d;
    ny_q     <= ny_d;
    ptag_q   <= ptag_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    nl_q     <= nl_d;
    minone_q <= minone_d;
  end

  // alarm memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  `CCAQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(QUEUE_DEPTH))
  `CCAQ_ASSERT_NXT(a_idle_queue_hold, state_q == ccaq_pkg::ST_IDLE, $stable(cnt_q) && $stable(head_q))
  `CCAQ_ASSERT_IMP(a_res_bound, 1'b1, nres_q <= ResW'(ccaq_pkg::MaxResults))
  `CCAQ_ASSERT_IMP(a_emit_busy, $rose(out_valid_q), $past(state_q) != ccaq_pkg::ST_IDLE)

endmodule
